FILE: rtl/core/square_window_min_filter_core_assert.svh
// Assertion macros for the square window minimum filter.
// SWMF_ASSERT checks a property on every clock edge out of reset.
// SWMF_ASSERT_NEVER checks that a condition is never true out of reset.
`ifndef SQUARE_WINDOW_MIN_FILTER_CORE_ASSERT_SVH
`define SQUARE_WINDOW_MIN_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SWMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SWMF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWMF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/core/swmf_pkg.sv
package swmf_pkg;

  localparam int PIX_W      = 32;
  localparam int POS_W      = 10;
  localparam int SIDE_REG_W = 11;
  localparam int WIN_REG_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam int MAX_SIDE_DEF   = 1024;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [SIDE_REG_W-1:0] SIDE_RESET = SIDE_REG_W'(1024);
  localparam logic [WIN_REG_W-1:0]  WIN_RESET  = WIN_REG_W'(3);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIDE = 1'b1;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } st_e;

  function automatic pix_t pix_min(input pix_t a, input pix_t b);
    pix_min = (a < b) ? a : b;
  endfunction

endpackage

FILE: rtl/core/swmf_hcell.sv
// One stage of the horizontal chain: holds the minimum of the last k+1
// pixels of the current row, built from the neighbor's previous value.
module swmf_hcell
  import swmf_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  logic restart_i,
  input  pix_t pix_i,
  input  pix_t prev_i,
  output pix_t min_o
);

  pix_t min_q;
  pix_t min_d;

  always_comb begin
    min_d = restart_i ? pix_i : pix_min(pix_i, prev_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      min_q <= min_d;
    end
  end

  assign min_o = min_q;

endmodule

FILE: rtl/core/swmf_vcell.sv
// One stage of the vertical chain: a line of per-column minima over the
// last k+1 row minima. New entry combines the current row minimum with the
// neighbor stage's entry from the previous row.
module swmf_vcell
  import swmf_pkg::*;
#(
  parameter int DEPTH = MAX_SIDE_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic          restart_i,
  input  pix_t          row_min_i,
  input  pix_t          prev_i,
  output pix_t          stored_o
);

  pix_t mem_q [DEPTH];
  pix_t rd_q;
  pix_t wr_data;

  always_comb begin
    wr_data = restart_i ? row_min_i : pix_min(row_min_i, prev_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign stored_o = rd_q;

endmodule

FILE: rtl/core/square_window_min_filter_core.sv
// Square window minimum filter (grayscale erosion). Pixels of a square image
// come in raster order; for every pixel whose row and column are both at
// least window-1 the block returns the minimum of the window x window block
// ending there, with the block's top-left position and a flag on the frame's
// last result. An item is handled by the line-store read issued when the item
// is taken, then by the vertical update and output load in ST_WORK. While an
// earlier result still sits in the output register under stall, the ST_WORK
// step repeats until that result leaves, and the input stays stalled.
// A horizontal chain of MAX_WINDOW cells keeps running row minima; a vertical
// chain of MAX_WINDOW-1 cells, each with its own MAX_SIDE-deep line memory,
// keeps running column minima over past rows. The line memories are not
// cleared after reset. Write image_side and window_side only between frames.
`include "square_window_min_filter_core_assert.svh"

module square_window_min_filter_core
  import swmf_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      block_min_o,
  output logic [POS_W-1:0]      out_row_o,
  output logic [POS_W-1:0]      out_col_o,
  output logic                  frame_last_o
);

  localparam int PW    = $clog2(MAX_SIDE + 1);
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int NCELL = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int HIW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CIW   = (NCELL > 1) ? $clog2(NCELL) : 1;

  // configuration
  logic [SIDE_REG_W-1:0] side_q;
  logic [WIN_REG_W-1:0]  win_q;
  logic [SIDE_REG_W-1:0] side_eff;
  logic [WIN_REG_W-1:0]  win_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
      win_q  <= WIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_SIDE:  side_q <= cfg_data_i[SIDE_REG_W-1:0];
        CFG_WINDOW_SIDE: win_q  <= cfg_data_i[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_q == '0) begin
      side_eff = SIDE_REG_W'(1);
    end else if (32'(side_q) > MAX_SIDE) begin
      side_eff = SIDE_REG_W'(MAX_SIDE);
    end else begin
      side_eff = side_q;
    end
    if (win_q == '0) begin
      win_eff = WIN_REG_W'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      win_eff = WIN_REG_W'(MAX_WINDOW);
    end else begin
      win_eff = win_q;
    end
  end

  // control
  st_e  st_q, st_d;
  logic accept;
  logic work_done;
  logic load_out;

  logic [PW-1:0] row_q, row_d;
  logic [PW-1:0] col_q, col_d;
  logic [PW-1:0] row0, col0, row1, row2, col1, cp1, rp1;
  logic          col_restart;
  logic          row_restart;
  logic          emit_row;
  logic          emit_blk;
  logic [AW-1:0] left;
  logic          is_last;

  logic             wr_q;
  logic             res_q;
  logic             restart_q;
  logic             last_q;
  logic [AW-1:0]    left_q;
  logic [POS_W-1:0] top_q;
  logic [POS_W-1:0] top_pos;

  assign accept = in_valid_i && !in_stall_o;

  // position of the incoming item
  always_comb begin
    col0 = frame_start_i ? '0 : col_q;
    row0 = frame_start_i ? '0 : row_q;
    if (32'(col0) >= 32'(side_eff)) begin
      col1 = '0;
      row1 = row0 + PW'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    row2 = (32'(row1) >= 32'(side_eff)) ? '0 : row1;
    cp1  = col1 + PW'(1);
    rp1  = row2 + PW'(1);
    col_restart = (col1 == '0);
    row_restart = (row2 == '0);
    emit_row = (32'(win_eff) <= 32'(side_eff)) && (32'(cp1) >= 32'(win_eff));
    emit_blk = emit_row && (32'(rp1) >= 32'(win_eff));
    left     = AW'(32'(cp1) - 32'(win_eff));
    top_pos  = POS_W'(32'(rp1) - 32'(win_eff));
    is_last  = (32'(rp1) == 32'(side_eff)) && (32'(cp1) == 32'(side_eff));
    row_d    = accept ? row2 : row_q;
    col_d    = accept ? cp1 : col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      row_q <= '0;
      col_q <= '0;
      wr_q  <= 1'b0;
      res_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      row_q <= row_d;
      col_q <= col_d;
      if (accept) begin
        wr_q  <= emit_row;
        res_q <= emit_blk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      restart_q <= row_restart;
      last_q    <= is_last;
      left_q    <= left;
      top_q     <= top_pos;
    end
  end

  // result can leave the work state unless the output slot is still held
  assign work_done = !res_q || !out_valid_o || !out_stall_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (accept) st_d = ST_WORK;
      ST_WORK: if (work_done) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (st_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_WORK: load_out = work_done && res_q;
      default: in_stall_o = 1'b1;
    endcase
  end

  // horizontal chain
  pix_t hmin [MAX_WINDOW];
  pix_t row_min;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_hcell
    pix_t prev;
    if (k == 0) begin : g_first
      assign prev = pix_t'(pixel_value_i);
    end else begin : g_next
      assign prev = hmin[k-1];
    end
    swmf_hcell u_hcell (
      .clk_i     (clk_i),
      .en_i      (accept),
      .restart_i (col_restart),
      .pix_i     (pix_t'(pixel_value_i)),
      .prev_i    (prev),
      .min_o     (hmin[k])
    );
  end

  assign row_min = hmin[HIW'(win_eff - WIN_REG_W'(1))];

  // vertical chain
  pix_t stored [NCELL];
  logic vwr_en;
  logic vrd_en;

  assign vwr_en = (st_q == ST_WORK) && wr_q;
  assign vrd_en = accept && emit_row;

  if (MAX_WINDOW > 1) begin : g_vchain
    for (genvar k = 0; k < NCELL; k++) begin : g_vcell
      pix_t prev;
      if (k == 0) begin : g_first
        assign prev = row_min;
      end else begin : g_next
        assign prev = stored[k-1];
      end
      swmf_vcell #(
        .DEPTH (MAX_SIDE)
      ) u_vcell (
        .clk_i     (clk_i),
        .rd_en_i   (vrd_en),
        .rd_addr_i (left),
        .wr_en_i   (vwr_en),
        .wr_addr_i (left_q),
        .restart_i (restart_q),
        .row_min_i (row_min),
        .prev_i    (prev),
        .stored_o  (stored[k])
      );
    end
  end else begin : g_no_vchain
    assign stored[0] = '0;
  end

  pix_t blk_min;

  always_comb begin
    if (win_eff == WIN_REG_W'(1)) begin
      blk_min = row_min;
    end else begin
      blk_min = pix_min(row_min, stored[CIW'(win_eff - WIN_REG_W'(2))]);
    end
  end

  // output register
  logic             out_valid_q;
  pix_t             block_min_q;
  logic [POS_W-1:0] out_row_q;
  logic [POS_W-1:0] out_col_q;
  logic             frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      block_min_q  <= blk_min;
      out_row_q    <= top_q;
      out_col_q    <= POS_W'(left_q);
      frame_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign block_min_o  = block_min_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = frame_last_q;

  `SWMF_ASSERT(a_accept_to_work, clk_i, rst_ni,
    accept |=> st_q == ST_WORK, "accepted item did not start work")
  `SWMF_ASSERT(a_result_from_work, clk_i, rst_ni,
    $rose(out_valid_o) |-> $past(st_q == ST_WORK && res_q), "result without block")
  `SWMF_ASSERT(a_last_on_diag, clk_i, rst_ni,
    (out_valid_o && frame_last_o) |-> out_row_o == out_col_o, "last block off corner")
  `SWMF_ASSERT_NEVER(a_row_in_range, clk_i, rst_ni,
    st_q == ST_WORK && 32'(row_q) >= 32'(side_eff), "row position past image side")

endmodule
